// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the phase-angle load timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define PAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Overlapping implication, antecedent and consequent in the same cycle.
`define PAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pat_pkg.sv =====
// Package for the phase-angle load timer: widths, request codes, drive table.
package pat_pkg;

    localparam int ReqW      = 4;
    localparam int LevelW    = 7;
    localparam int OnTimeW   = 14;
    localparam int ElapsedW  = 16;

    // Request codes
    localparam logic [ReqW-1:0] ReqTick   = 4'd0;
    localparam logic [ReqW-1:0] ReqCross  = 4'd1;
    localparam logic [ReqW-1:0] ReqUp     = 4'd2;
    localparam logic [ReqW-1:0] ReqDown   = 4'd3;
    localparam logic [ReqW-1:0] ReqSet    = 4'd4;
    localparam logic [ReqW-1:0] ReqOn     = 4'd5;
    localparam logic [ReqW-1:0] ReqOff    = 4'd6;
    localparam logic [ReqW-1:0] ReqToggle = 4'd7;
    localparam logic [ReqW-1:0] ReqPause  = 4'd8;
    localparam logic [ReqW-1:0] ReqResume = 4'd9;

    localparam logic [LevelW-1:0]   LevelMax   = 7'd100;
    localparam logic [LevelW-1:0]   LevelStep  = 7'd5;
    localparam logic [LevelW-1:0]   UpLimit    = 7'd95;
    localparam logic [OnTimeW-1:0]  OnTimeMax  = 14'd10000;
    localparam logic [ElapsedW-1:0] ElapsedMax = 16'hFFFF;

    // State seen at the output after each item
    typedef struct packed {
        logic                load_drive;
        logic [LevelW-1:0]   level;
        logic [OnTimeW-1:0]  on_time;
        logic                powered;
    } t_pat_view;

    // Drive time in microseconds for a level, one step per five percent
    function automatic logic [OnTimeW-1:0] drive_time(input logic [LevelW-1:0] lvl);
        logic [OnTimeW-1:0] t;
        case (lvl) inside
            [7'd0:7'd4]:   t = 14'd0;
            [7'd5:7'd9]:   t = 14'd1436;
            [7'd10:7'd14]: t = 14'd2048;
            [7'd15:7'd19]: t = 14'd2532;
            [7'd20:7'd24]: t = 14'd2952;
            [7'd25:7'd29]: t = 14'd3333;
            [7'd30:7'd34]: t = 14'd3690;
            [7'd35:7'd39]: t = 14'd4030;
            [7'd40:7'd44]: t = 14'd4359;
            [7'd45:7'd49]: t = 14'd4681;
            [7'd50:7'd54]: t = 14'd5000;
            [7'd55:7'd59]: t = 14'd5319;
            [7'd60:7'd64]: t = 14'd5641;
            [7'd65:7'd69]: t = 14'd5970;
            [7'd70:7'd74]: t = 14'd6310;
            [7'd75:7'd79]: t = 14'd6667;
            [7'd80:7'd84]: t = 14'd7048;
            [7'd85:7'd89]: t = 14'd7468;
            [7'd90:7'd94]: t = 14'd7952;
            [7'd95:7'd99]: t = 14'd8564;
            default:       t = OnTimeMax;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/pat_core.sv =====
// Timer state and event decode for the phase-angle load timer.
module pat_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [pat_pkg::ReqW-1:0]     i_req,
    input  logic [pat_pkg::LevelW-1:0]   i_lvl,
    output pat_pkg::t_pat_view           o_view
);

    logic [pat_pkg::LevelW-1:0]   r_level,   n_level;
    logic [pat_pkg::OnTimeW-1:0]  r_on_time, n_on_time;
    logic [pat_pkg::ElapsedW-1:0] r_elapsed, n_elapsed;
    logic                         r_powered, n_powered;
    logic                         r_paused,  n_paused;
    logic [pat_pkg::LevelW-1:0]   set_lvl;

    // Clamp for set level
    assign set_lvl = (i_lvl > pat_pkg::LevelMax) ? pat_pkg::LevelMax : i_lvl;

    // Next state for the item in hand
    always_comb begin
        n_level   = r_level;
        n_on_time = r_on_time;
        n_elapsed = r_elapsed;
        n_powered = r_powered;
        n_paused  = r_paused;
        case (i_req)
            pat_pkg::ReqTick: begin
                if (r_elapsed != pat_pkg::ElapsedMax) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            pat_pkg::ReqCross: begin
                if (r_powered && !r_paused) begin
                    n_elapsed = '0;
                end
            end
            pat_pkg::ReqUp: begin
                if (r_powered && r_level <= pat_pkg::UpLimit) begin
                    n_level   = r_level + pat_pkg::LevelStep;
                    n_on_time = pat_pkg::drive_time(r_level + pat_pkg::LevelStep);
                end
            end
            pat_pkg::ReqDown: begin
                if (r_powered && r_level >= pat_pkg::LevelStep) begin
                    n_level   = r_level - pat_pkg::LevelStep;
                    n_on_time = pat_pkg::drive_time(r_level - pat_pkg::LevelStep);
                end
            end
            pat_pkg::ReqSet: begin
                if (r_powered) begin
                    n_level   = set_lvl;
                    n_on_time = pat_pkg::drive_time(set_lvl);
                end
            end
            pat_pkg::ReqOn:     n_powered = 1'b1;
            pat_pkg::ReqOff:    n_powered = 1'b0;
            pat_pkg::ReqToggle: n_powered = !r_powered;
            pat_pkg::ReqPause:  n_paused  = 1'b1;
            pat_pkg::ReqResume: n_paused  = 1'b0;
            default: begin
            end
        endcase
    end

    // State registers, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_on_time <= '0;
            r_elapsed <= '0;
            r_powered <= 1'b1;
            r_paused  <= 1'b0;
        end else if (i_step) begin
            r_level   <= n_level;
            r_on_time <= n_on_time;
            r_elapsed <= n_elapsed;
            r_powered <= n_powered;
            r_paused  <= n_paused;
        end
    end

    // View after the item
    assign o_view.load_drive = n_powered && (n_elapsed < {2'b00, n_on_time});
    assign o_view.level      = n_level;
    assign o_view.on_time    = n_on_time;
    assign o_view.powered    = n_powered;

endmodule

// ===== hw/rtl/phase_angle_load_timer.sv =====
// Top level of the phase-angle load timer: input and result registers.
//
// Input channel: i_valid, o_stall, fields i_req_type and i_new_level. An item is
// taken at a clock edge with i_valid high and o_stall low. Each item is one event:
// tick, zero crossing, level up/down, set level, on, off, toggle, pause, resume.
// Output channel: o_valid, i_stall, fields o_load_drive, o_level_now,
// o_on_time_us and o_is_on. Every item gives exactly one result showing the
// state after that event.
// An accepted item is held in the input register, and its result is then loaded into
// the result register, which drives o_valid. One item per cycle is sustained while
// i_stall is low, as the state update is a single pass of logic between the input
// register and the result register.
// While i_stall holds the result, one further item waits in the input register;
// o_stall rises only when both registers are full.
// Reset (synchronous, active low) empties both registers and sets level 0,
// drive time 0, elapsed time 0, switched on, crossings accepted.
module phase_angle_load_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pat_pkg::ReqW-1:0]      i_req_type,
    input  logic [pat_pkg::LevelW-1:0]    i_new_level,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_load_drive,
    output logic [pat_pkg::LevelW-1:0]    o_level_now,
    output logic [pat_pkg::OnTimeW-1:0]   o_on_time_us,
    output logic                          o_is_on
);

`include "assert_macros.svh"

    logic                         r_in_valid;
    logic [pat_pkg::ReqW-1:0]     r_req;
    logic [pat_pkg::LevelW-1:0]   r_lvl;
    logic                         r_out_valid;
    pat_pkg::t_pat_view           r_view;
    pat_pkg::t_pat_view           view;
    logic                         advance;
    logic                         take;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req_type;
            r_lvl <= i_new_level;
        end
    end

    pat_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (r_req),
        .i_lvl   (r_lvl),
        .o_view  (view)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_view <= view;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_load_drive = r_view.load_drive;
    assign o_level_now  = r_view.level;
    assign o_on_time_us = r_view.on_time;
    assign o_is_on      = r_view.powered;

    // Checks
    `PAT_ASSERT_IMP(a_drive_needs_power, i_clk, i_rst_n,
        r_out_valid && o_load_drive, o_is_on, "load driven while off")
    `PAT_ASSERT_IMP(a_level_range, i_clk, i_rst_n,
        r_out_valid, o_level_now <= pat_pkg::LevelMax, "level above maximum")
    `PAT_ASSERT_IMP(a_on_time_range, i_clk, i_rst_n,
        r_out_valid, o_on_time_us <= pat_pkg::OnTimeMax, "drive time above maximum")
    `PAT_ASSERT(a_stall_only_full, i_clk, i_rst_n,
        !o_stall || (r_in_valid && r_out_valid && i_stall), "input stalled with room free")

endmodule

// ===== test/tb_phase_angle_load_timer.sv =====
// Testbench for the phase-angle load timer: a directed event table, then random events.
module tb_phase_angle_load_timer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ReqW     = pat_pkg::ReqW;
    localparam int LevelW   = pat_pkg::LevelW;
    localparam int OnTimeW  = pat_pkg::OnTimeW;
    localparam int ElapsedW = pat_pkg::ElapsedW;

    // Request codes the block treats as no-ops
    localparam logic [ReqW-1:0] ReqSpareLo = 4'd10;
    localparam logic [ReqW-1:0] ReqSpareHi = 4'd15;

    localparam int RandEvents = 1140;
    localparam int IdlePct    = 32;
    localparam int QuietFrom  = 500;
    localparam int QuietTo    = 700;
    localparam int StuckLimit = 500;
    localparam int NumRows    = 46;

    // Drive time per five-percent step
    localparam logic [OnTimeW-1:0] StepDriveUs [21] = '{
        14'd0, 14'd1436, 14'd2048, 14'd2532, 14'd2952, 14'd3333, 14'd3690,
        14'd4030, 14'd4359, 14'd4681, 14'd5000, 14'd5319, 14'd5641, 14'd5970,
        14'd6310, 14'd6667, 14'd7048, 14'd7468, 14'd7952, 14'd8564, 14'd10000
    };

    typedef struct packed {
        logic [ReqW-1:0]    req;
        logic [LevelW-1:0]  lvl;
        bit                 typed;
        pat_pkg::t_pat_view want;
    } t_event;

    typedef struct packed {
        logic [ReqW-1:0]    req;
        logic [LevelW-1:0]  lvl;
        logic [7:0]         reps;
        bit                 typed;
        pat_pkg::t_pat_view want;
    } t_row;

    // Directed events: request, level, repeats, typed, expected view
    localparam t_row DirRows [NumRows] = '{
        '{pat_pkg::ReqTick,   7'd0,   8'd1,  1'b1, '{1'b0, 7'd0,   14'd0,     1'b1}},
        '{pat_pkg::ReqSet,    7'd127, 8'd1,  1'b1, '{1'b1, 7'd100, 14'd10000, 1'b1}},
        '{pat_pkg::ReqUp,     7'd0,   8'd1,  1'b1, '{1'b1, 7'd100, 14'd10000, 1'b1}},
        '{pat_pkg::ReqOff,    7'd0,   8'd1,  1'b1, '{1'b0, 7'd100, 14'd10000, 1'b0}},
        '{pat_pkg::ReqSet,    7'd50,  8'd1,  1'b1, '{1'b0, 7'd100, 14'd10000, 1'b0}},
        '{pat_pkg::ReqUp,     7'd0,   8'd1,  1'b1, '{1'b0, 7'd100, 14'd10000, 1'b0}},
        '{pat_pkg::ReqDown,   7'd0,   8'd1,  1'b1, '{1'b0, 7'd100, 14'd10000, 1'b0}},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqOn,     7'd0,   8'd1,  1'b1, '{1'b1, 7'd100, 14'd10000, 1'b1}},
        '{pat_pkg::ReqSet,    7'd0,   8'd1,  1'b1, '{1'b0, 7'd0,   14'd0,     1'b1}},
        '{pat_pkg::ReqDown,   7'd0,   8'd1,  1'b1, '{1'b0, 7'd0,   14'd0,     1'b1}},
        '{pat_pkg::ReqUp,     7'd0,   8'd20, 1'b0, '0},
        '{pat_pkg::ReqUp,     7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqDown,   7'd0,   8'd21, 1'b0, '0},
        '{pat_pkg::ReqSet,    7'd4,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd5,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd99,  8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd100, 8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd101, 8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd96,  8'd1,  1'b0, '0},
        '{pat_pkg::ReqUp,     7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd95,  8'd1,  1'b0, '0},
        '{pat_pkg::ReqUp,     7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqPause,  7'd0,   8'd2,  1'b0, '0},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqTick,   7'd0,   8'd40, 1'b0, '0},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqResume, 7'd0,   8'd2,  1'b0, '0},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqTick,   7'd0,   8'd30, 1'b0, '0},
        '{pat_pkg::ReqToggle, 7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqTick,   7'd0,   8'd5,  1'b0, '0},
        '{pat_pkg::ReqToggle, 7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqOff,    7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqPause,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqToggle, 7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqCross,  7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqResume, 7'd0,   8'd1,  1'b0, '0},
        '{ReqSpareLo,         7'd55,  8'd1,  1'b0, '0},
        '{ReqSpareHi,         7'd127, 8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd3,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqDown,   7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqSet,    7'd7,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqDown,   7'd0,   8'd1,  1'b0, '0},
        '{pat_pkg::ReqDown,   7'd0,   8'd1,  1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 valid = 1'b0;
    logic                 o_stall;
    logic [ReqW-1:0]      req = '0;
    logic [LevelW-1:0]    lvl = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_load_drive;
    logic [LevelW-1:0]    o_level_now;
    logic [OnTimeW-1:0]   o_on_time_us;
    logic                 o_is_on;

    t_event               events[$];
    pat_pkg::t_pat_view   exp_q[$];
    pat_pkg::t_pat_view   pred_v;
    pat_pkg::t_pat_view   exp_v;
    pat_pkg::t_pat_view   got_v;
    int                   in_count  = 0;
    int                   out_count = 0;
    int                   errors    = 0;
    int                   stuck     = 0;

    // Predictor state
    logic [LevelW-1:0]    m_level   = '0;
    logic [OnTimeW-1:0]   m_on_time = '0;
    logic [ElapsedW-1:0]  m_elapsed = '0;
    logic                 m_powered = 1'b1;
    logic                 m_paused  = 1'b0;

    phase_angle_load_timer u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (valid),
        .o_stall      (o_stall),
        .i_req_type   (req),
        .i_new_level  (lvl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_load_drive (o_load_drive),
        .o_level_now  (o_level_now),
        .o_on_time_us (o_on_time_us),
        .o_is_on      (o_is_on)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Level change, ignored while off, clamped to the top
    function automatic void apply_level(input logic [LevelW-1:0] lv);
        logic [LevelW-1:0] lv_c;
        int                idx;
        if (m_powered) begin
            lv_c      = (lv > pat_pkg::LevelMax) ? pat_pkg::LevelMax : lv;
            idx       = int'(lv_c) / 5;
            m_level   = lv_c;
            m_on_time = StepDriveUs[idx];
        end
    endfunction

    // Predictor: advance the state by one item and return the view
    function automatic pat_pkg::t_pat_view predict(input logic [ReqW-1:0] rq,
                                                   input logic [LevelW-1:0] lv);
        pat_pkg::t_pat_view v;
        case (rq)
            pat_pkg::ReqTick: begin
                if (m_elapsed != pat_pkg::ElapsedMax) begin
                    m_elapsed = m_elapsed + 16'd1;
                end
            end
            pat_pkg::ReqCross: begin
                if (m_powered && !m_paused) begin
                    m_elapsed = '0;
                end
            end
            pat_pkg::ReqUp: begin
                if (m_level <= pat_pkg::UpLimit) begin
                    apply_level(m_level + pat_pkg::LevelStep);
                end
            end
            pat_pkg::ReqDown: begin
                if (m_level >= pat_pkg::LevelStep) begin
                    apply_level(m_level - pat_pkg::LevelStep);
                end
            end
            pat_pkg::ReqSet:    apply_level(lv);
            pat_pkg::ReqOn:     m_powered = 1'b1;
            pat_pkg::ReqOff:    m_powered = 1'b0;
            pat_pkg::ReqToggle: m_powered = !m_powered;
            pat_pkg::ReqPause:  m_paused  = 1'b1;
            pat_pkg::ReqResume: m_paused  = 1'b0;
            default: begin
            end
        endcase
        v.load_drive = m_powered && (m_elapsed < {2'b00, m_on_time});
        v.level      = m_level;
        v.on_time    = m_on_time;
        v.powered    = m_powered;
        return v;
    endfunction

    // Directed table expanded, then random events
    task automatic build_events();
        t_event e;
        int     pick;
        for (int r = 0; r < NumRows; r++) begin
            e.req   = DirRows[r].req;
            e.lvl   = DirRows[r].lvl;
            e.typed = DirRows[r].typed;
            e.want  = DirRows[r].want;
            for (int k = 0; k < int'(DirRows[r].reps); k++) begin
                events.push_back(e);
            end
        end
        for (int k = 0; k < RandEvents; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                e.req = pat_pkg::ReqTick;
            end else if (pick < 55) begin
                e.req = pat_pkg::ReqCross;
            end else begin
                e.req = ReqW'($urandom_range(15));
            end
            e.lvl   = LevelW'($urandom_range(127));
            e.typed = 1'b0;
            e.want  = '0;
            events.push_back(e);
        end
    endtask

    // Reset, input driver and end of run
    initial begin : drive
        int n_sent;
        n_sent = 0;
        build_events();
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (n_sent < events.size()) begin
            @(posedge clk);
            if (valid && !o_stall) begin
                n_sent++;
            end
            if (!valid || !o_stall) begin
                if (n_sent < events.size() &&
                    ((n_sent >= QuietFrom && n_sent < QuietTo) ||
                     $urandom_range(99) >= IdlePct)) begin
                    valid <= 1'b1;
                    req   <= events[n_sent].req;
                    lvl   <= events[n_sent].lvl;
                end else begin
                    valid <= 1'b0;
                end
            end
        end
        wait (out_count == events.size());
        repeat (4) @(posedge clk);
        if (errors == 0 && exp_q.size() == 0) begin
            $display("tb_phase_angle_load_timer: done, clean");
        end else begin
            $display("tb_phase_angle_load_timer: done, errors");
        end
        $finish;
    end

    // Receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            i_stall <= 1'b0;
        end else if (out_count >= QuietFrom && out_count < QuietTo) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < IdlePct);
        end
    end

    // Expected view for every accepted item
    always @(posedge clk) begin
        if (rst_n && valid && !o_stall) begin
            pred_v = predict(req, lvl);
            if (events[in_count].typed) begin
                exp_q.push_back(events[in_count].want);
            end else begin
                exp_q.push_back(pred_v);
            end
            in_count++;
        end
    end

    // Result check
    always @(posedge clk) begin
        if (rst_n && o_valid && !i_stall) begin
            got_v = {o_load_drive, o_level_now, o_on_time_us, o_is_on};
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_v);
                errors++;
            end else begin
                exp_v = exp_q.pop_front();
                if (got_v !== exp_v) begin
                    $display("%0t: item %0d mismatch, expected %h, actual %h",
                             $time, out_count, exp_v, got_v);
                    errors++;
                end
            end
            out_count++;
        end
    end

    // Watchdog on cycles with nothing accepted
    always @(posedge clk) begin
        if (!rst_n || (valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= StuckLimit) begin
                $display("%0t: no item accepted for %0d cycles", $time, stuck);
                $display("tb_phase_angle_load_timer: done, errors");
                $finish;
            end
        end
    end

endmodule
